// ===== rtl/mfp_pkg.sv =====
// Shared types and constants for the message frame parser.
// No dependencies; imported by every module of the block.
package mfp_pkg;

	localparam logic [7:0] MAGIC_A = 8'hAA;
	localparam logic [7:0] MAGIC_B = 8'h55;
	localparam logic [2:0] HDR_LEN = 3'd7;

	localparam logic [2:0] IDX_MAGIC_A = 3'd0;
	localparam logic [2:0] IDX_MAGIC_B = 3'd1;
	localparam logic [2:0] IDX_TYPE    = 3'd2;
	localparam logic [2:0] IDX_LEN_LO  = 3'd3;
	localparam logic [2:0] IDX_LEN_HI  = 3'd4;
	localparam logic [2:0] IDX_REQ_LO  = 3'd5;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SHORT     = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
	localparam logic [1:0] ST_MISMATCH  = 2'd3;

	localparam int OUT_TDATA_W = 56;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_type;
		logic [15:0] request_id;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
		logic [1:0]  status;
		logic        last;
	} result_t;

endpackage

// ===== rtl/message_frame_parser_unit.sv =====
// Top level of the message frame parser: input register, parser, result queue.
// Depends on mfp_pkg, mfp_parse and mfp_out_buf.
//
// Usage:
//   Input stream carries one buffer byte per item in s_axis_tdata[7:0];
//   s_axis_tlast marks the final byte of the buffer.
//   Output stream carries results: m_axis_tuser gives the kind (header, payload
//   byte, end status), m_axis_tlast is set on the end status of a buffer.
//   The consumer drops payload bytes of a buffer whose end status is not ok.
// Path: an accepted byte is held in the input register, and its results are
//   written to the result queue, which drives the output.
// Throughput: one byte per cycle unless the receiver stalls; the two-entry
//   result queue sets it; a byte with header and end status needs both slots.
// Bytes of a bad-magic buffer after the header yield no result other than
//   the end status on the final byte.
// Reset clears the parse state and empties the queue; the block then
//   expects the first byte of a new buffer.
// When the receiver stalls, results hold in the queue and the input
//   register, and s_axis_tready drops once neither can take more.
module message_frame_parser_unit import mfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
	input  logic                   s_axis_tlast,   // end_of_buffer
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] msg_type, [23:8] request_id, [39:24] payload_length,
	// [47:40] data_byte, [49:48] status, [55:50] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser,   // [1:0] kind
	output logic                   m_axis_tlast    // last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       go;
	result_t    res0;
	result_t    res1;
	result_t    out_res;
	logic [1:0] res_count;
	logic [1:0] space;
	logic [1:0] push_count;

	assign go            = valid_s1 && (res_count <= space);
	assign s_axis_tready = !valid_s1 || go;
	assign push_count    = go ? res_count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eob_s1  <= s_axis_tlast;
		end
	end

	mfp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (go),
		.rx_byte       (byte_s1),
		.end_of_buffer (eob_s1),
		.res0          (res0),
		.res1          (res1),
		.res_count     (res_count)
	);

	mfp_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.space      (space),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.status, out_res.data_byte, out_res.payload_length,
		out_res.request_id, out_res.msg_type};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule

// ===== rtl/mfp_parse.sv =====
// Header/payload parse state and per-item result decode.
// Depends on mfp_pkg for constants and result_t.
module mfp_parse import mfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] rx_byte,
	input  logic       end_of_buffer,
	output result_t    res0,
	output result_t    res1,
	output logic [1:0] res_count
);

	logic [2:0]  hi_q, hi_d;
	logic [15:0] pc_q, pc_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] req_q, req_d;
	logic        mb_q, mb_d;
	logic        ov_q, ov_d;
	logic        has_first;
	result_t     first_r;
	result_t     end_r;

	always_comb begin
		hi_d      = hi_q;
		pc_d      = pc_q;
		type_d    = type_q;
		len_d     = len_q;
		req_d     = req_q;
		mb_d      = mb_q;
		ov_d      = ov_q;
		has_first = 1'b0;
		first_r   = '0;
		end_r     = '0;
		if (hi_q != HDR_LEN) begin
			case (hi_q)
				IDX_MAGIC_A: if (rx_byte != MAGIC_A) mb_d = 1'b1;
				IDX_MAGIC_B: if (rx_byte != MAGIC_B) mb_d = 1'b1;
				IDX_TYPE:    type_d = rx_byte;
				IDX_LEN_LO:  len_d = {len_q[15:8], rx_byte};
				IDX_LEN_HI:  len_d = {rx_byte, len_q[7:0]};
				IDX_REQ_LO:  req_d = {req_q[15:8], rx_byte};
				default:     req_d = {rx_byte, req_q[7:0]};
			endcase
			hi_d = hi_q + 3'd1;
			if (hi_d == HDR_LEN && !mb_d) begin
				has_first              = 1'b1;
				first_r.kind           = KIND_HEADER;
				first_r.msg_type       = type_d;
				first_r.request_id     = req_d;
				first_r.payload_length = len_d;
			end
		end else if (!mb_q) begin
			if (pc_q == 16'hFFFF) begin
				ov_d = 1'b1;
			end else begin
				pc_d = pc_q + 16'd1;
			end
			has_first         = 1'b1;
			first_r.kind      = KIND_PAYLOAD;
			first_r.data_byte = rx_byte;
		end
		if (end_of_buffer) begin
			end_r.kind = KIND_END;
			end_r.last = 1'b1;
			if (hi_d != HDR_LEN) begin
				end_r.status = ST_SHORT;
			end else if (mb_d) begin
				end_r.status = ST_BAD_MAGIC;
			end else if (ov_d || pc_d != len_d) begin
				end_r.status = ST_MISMATCH;
			end else begin
				end_r.status = ST_OK;
			end
			hi_d   = '0;
			pc_d   = '0;
			type_d = '0;
			len_d  = '0;
			req_d  = '0;
			mb_d   = 1'b0;
			ov_d   = 1'b0;
		end
	end

	assign res0      = has_first ? first_r : end_r;
	assign res1      = end_r;
	assign res_count = {1'b0, has_first} + {1'b0, end_of_buffer};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q   <= '0;
			pc_q   <= '0;
			type_q <= '0;
			len_q  <= '0;
			req_q  <= '0;
			mb_q   <= 1'b0;
			ov_q   <= 1'b0;
		end else if (advance) begin
			hi_q   <= hi_d;
			pc_q   <= pc_d;
			type_q <= type_d;
			len_q  <= len_d;
			req_q  <= req_d;
			mb_q   <= mb_d;
			ov_q   <= ov_d;
		end
	end

endmodule

// ===== rtl/mfp_out_buf.sv =====
// Two-entry result queue that takes up to two results per cycle.
// Depends on mfp_pkg for result_t.
module mfp_out_buf import mfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  result_t    push0,
	input  result_t    push1,
	output logic [1:0] space,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_res
);

	result_t    buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign space     = (2'd2 - cnt_q) + {1'b0, pop};
	assign out_res   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			buf_q[wr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			buf_q[~wr_q] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q ^ push_count[0];
			rd_q  <= rd_q ^ pop;
			cnt_q <= cnt_q + push_count - {1'b0, pop};
		end
	end

endmodule

// ===== bench/frame_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for message_frame_parser_unit: watches both streams, predicts
// the results of every accepted byte and compares them in order. Depends on mfp_pkg.
module frame_result_checker import mfp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [7:0]             s_tdata,    // [7:0] rx_byte
	input  logic                   s_tlast,    // end_of_buffer
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	// [7:0] msg_type, [23:8] request_id, [39:24] payload_length,
	// [47:40] data_byte, [49:48] status, [55:50] zero
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [1:0]             m_tuser,    // [1:0] kind
	input  logic                   m_tlast,    // last
	output int                     fail_count,
	output int                     pending
);

	logic [2:0]  hdr_seen;
	logic [15:0] body_count;
	logic [7:0]  type_q;
	logic [15:0] len_q;
	logic [15:0] req_q;
	logic        magic_err;
	logic        body_overrun;
	result_t     frame_results[$];
	result_t     want;

	task automatic clear_parse();
		hdr_seen = '0;
		body_count = '0;
		type_q = '0;
		len_q = '0;
		req_q = '0;
		magic_err = 1'b0;
		body_overrun = 1'b0;
	endtask

	function automatic result_t blank_result(input logic [1:0] k);
		result_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	task automatic queue_result(input result_t r);
		frame_results.insert(frame_results.size(), r);
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic fin);
		result_t r;
		if (hdr_seen < HDR_LEN) begin
			case (hdr_seen)
				IDX_MAGIC_A: if (b != MAGIC_A) magic_err = 1'b1;
				IDX_MAGIC_B: if (b != MAGIC_B) magic_err = 1'b1;
				IDX_TYPE:    type_q = b;
				IDX_LEN_LO:  len_q[7:0] = b;
				IDX_LEN_HI:  len_q[15:8] = b;
				IDX_REQ_LO:  req_q[7:0] = b;
				default:     req_q[15:8] = b;
			endcase
			hdr_seen = hdr_seen + 3'd1;
			if (hdr_seen == HDR_LEN && !magic_err) begin
				r = blank_result(KIND_HEADER);
				r.msg_type = type_q;
				r.request_id = req_q;
				r.payload_length = len_q;
				queue_result(r);
			end
		end else if (!magic_err) begin
			if (body_count == 16'hFFFF)
				body_overrun = 1'b1;
			else
				body_count = body_count + 16'd1;
			r = blank_result(KIND_PAYLOAD);
			r.data_byte = b;
			queue_result(r);
		end
		if (fin) begin
			r = blank_result(KIND_END);
			r.last = 1'b1;
			if (hdr_seen < HDR_LEN)
				r.status = ST_SHORT;
			else if (magic_err)
				r.status = ST_BAD_MAGIC;
			else if (body_overrun || body_count != len_q)
				r.status = ST_MISMATCH;
			else
				r.status = ST_OK;
			queue_result(r);
			clear_parse();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			frame_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (frame_results.size() == 0) begin
					$error("kind: expected no item, got %0h", m_tuser);
					fail_count++;
				end else begin
					want = frame_results.pop_front();
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("msg_type", 32'(want.msg_type), 32'(m_tdata[7:0]));
					check_field("request_id", 32'(want.request_id), 32'(m_tdata[23:8]));
					check_field("payload_length", 32'(want.payload_length),
						32'(m_tdata[39:24]));
					check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[47:40]));
					check_field("status", 32'(want.status), 32'(m_tdata[49:48]));
					check_field("pad", 32'd0, 32'(m_tdata[55:50]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
		end
		pending = frame_results.size();
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for message_frame_parser_unit: clock, reset, buffer stimulus and
// random stalls on both streams; checking is done by frame_result_checker.
module tb_top;
	import mfp_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;
	int                     fail_count;
	int                     pending;
	int                     sent_items;
	int                     random_base;
	bit                     snd_calm;
	bit                     rcv_calm;

	message_frame_parser_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	frame_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = draw_gap(snd_calm);
		if (gap != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sent_items++;
	endtask

	// total_n of zero sends the full header and body; otherwise cut the buffer there
	task automatic send_frame(input logic [7:0] ma, input logic [7:0] mb, input logic [7:0] mtype,
			input logic [15:0] dlen, input logic [15:0] rid, input int body_n, input int total_n);
		logic [7:0] hdr [7];
		int n;
		hdr[0] = ma;
		hdr[1] = mb;
		hdr[2] = mtype;
		hdr[3] = dlen[7:0];
		hdr[4] = dlen[15:8];
		hdr[5] = rid[7:0];
		hdr[6] = rid[15:8];
		n = (total_n > 0) ? total_n : 7 + body_n;
		for (int i = 0; i < n; i++)
			send_byte((i < 7) ? hdr[i] : body_byte(), i == n - 1);
	endtask

	task automatic send_random_buffer();
		int pick;
		int body_n;
		logic [15:0] dlen;
		logic [7:0] ma;
		logic [7:0] mb;
		pick = $urandom_range(0, 99);
		snd_calm = ($urandom_range(0, 3) == 0);
		if (pick < 65) begin
			dlen = 16'($urandom_range(0, 12));
			body_n = int'(dlen);
			case ($urandom_range(0, 4))
				0: body_n = $urandom_range(0, 14);
				1: begin
					dlen = 16'($urandom);
					body_n = $urandom_range(0, 12);
				end
				default: ;
			endcase
			send_frame(MAGIC_A, MAGIC_B, 8'($urandom), dlen, 16'($urandom), body_n, 0);
		end else if (pick < 75) begin
			ma = MAGIC_A;
			mb = MAGIC_B;
			if ($urandom_range(0, 1))
				ma = MAGIC_A ^ 8'($urandom_range(1, 255));
			else
				mb = MAGIC_B ^ 8'($urandom_range(1, 255));
			send_frame(ma, mb, 8'($urandom), 16'($urandom_range(0, 8)), 16'($urandom),
				$urandom_range(0, 8), $urandom_range(0, 1) ? 0 : $urandom_range(1, 15));
		end else if (pick < 88) begin
			send_frame(MAGIC_A, MAGIC_B, 8'($urandom), 16'($urandom), 16'($urandom), 0,
				$urandom_range(1, 7));
		end else begin
			send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 0,
				$urandom_range(1, 15));
		end
	endtask

	initial begin
		int gap;
		int run_left;
		m_tready = 1'b0;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			if (run_left == 0) begin
				rcv_calm = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(20, 100);
			end
			run_left--;
			gap = draw_gap(rcv_calm);
			if (gap != 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		sent_items = 0;
		snd_calm = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		send_frame(MAGIC_A, MAGIC_B, 8'h00, 16'h0000, 16'h0000, 0, 1);
		send_frame(MAGIC_A, MAGIC_B, 8'h00, 16'h0000, 16'h0000, 0, 0);
		send_frame(MAGIC_A, MAGIC_B, 8'hFF, 16'h0002, 16'hFFFF, 2, 0);
		send_frame(MAGIC_A, 8'h00, 8'h5A, 16'h0000, 16'h0000, 0, 2);
		send_frame(8'h00, MAGIC_B, 8'h11, 16'h0001, 16'h1234, 1, 0);
		send_frame(MAGIC_A, MAGIC_B, 8'h80, 16'h0100, 16'h8001, 0, 0);
		send_frame(MAGIC_A, MAGIC_B, 8'h7E, 16'h0000, 16'h00FF, 2, 0);

		random_base = sent_items;
		while (sent_items - random_base < 1850)
			send_random_buffer();

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mfp_pkg.sv
rtl/mfp_parse.sv
rtl/mfp_out_buf.sv
rtl/message_frame_parser_unit.sv
bench/frame_result_checker.sv
bench/tb_top.sv
